@@ hdl/stsp_pkg.sv @@
package stsp_pkg;

    localparam int unsigned WordLimitDefault = 1048576;

    localparam logic [31:0] PS_3_0         = 32'hffff0300;
    localparam logic [31:0] OP_MOV         = 32'h02000001;
    localparam logic [31:0] OP_MAX         = 32'h0300000b;
    localparam logic [31:0] OP_DEF         = 32'h05000051;
    localparam logic [31:0] OP_END         = 32'h0000ffff;
    localparam logic [31:0] SAT_BIT        = 32'h00100000;
    localparam logic [31:0] DEST_FREE_MASK = 32'h0020001f;
    localparam logic [31:0] DEST_REQUIRED  = 32'h80170000;
    localparam logic [31:0] SRC_REQUIRED   = 32'h90e40000;
    localparam logic [31:0] DEF_DEST_BASE  = 32'ha00f0000;
    localparam logic [63:0] FNV_BASIS      = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME      = 64'h00000100000001b3;

    localparam logic [2:0] CFG_WORD_COUNT = 3'd0;
    localparam logic [2:0] CFG_HASH       = 3'd1;
    localparam logic [2:0] CFG_SITE_COUNT = 3'd2;
    localparam logic [2:0] CFG_SITE0      = 3'd3;
    localparam logic [2:0] CFG_SITE1      = 3'd4;
    localparam logic [2:0] CFG_DESTS      = 3'd5;
    localparam logic [2:0] CFG_ZERO_DEF   = 3'd6;
    localparam logic [2:0] CFG_ZERO_COMP  = 3'd7;

    localparam logic [1:0] ST_APPLIED  = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_BAD_PROF = 2'd3;

    typedef enum logic [1:0] {
        CTX_PLAIN = 2'd0,
        CTX_DEF   = 2'd1,
        CTX_SITE  = 2'd2,
        CTX_MOV   = 2'd3
    } t_ctx;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [31:0] out_word;
        logic [1:0]  status;
        logic        end_of_run;
    } t_out;

endpackage

@@ hdl/shader_token_stream_patcher_unit.sv @@
// a transaction is hashed one fnv byte step per cycle through one shared multiply, then
// evaluated, and its word result is shown after the hash and evaluation states
// a word is accepted only in idle, once the previous result, any zero operand a site
// emits and any status the last word adds are taken; a receiver stall holds the outputs
// reset: synchronous active-low; registers clear to zero, save the hash (fnv offset
// basis), the next-token index (one) and the state register (idle)
module shader_token_stream_patcher_unit #(
    parameter int unsigned WORD_LIMIT = stsp_pkg::WordLimitDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  stsp_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output stsp_pkg::t_out  o_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [63:0]     i_cfg_data
);
    import stsp_pkg::*;

    localparam int IW = 21;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_HASH = 6'b000010,
        S_EVAL = 6'b000100,
        S_OUT1 = 6'b001000,
        S_OUT2 = 6'b010000,
        S_STAT = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    logic [20:0] r_exp_count;
    logic [63:0] r_exp_hash;
    logic [1:0]  r_site_count;
    logic [19:0] r_site0, r_site1, r_zero_def;
    logic [63:0] r_dests;
    logic [1:0]  r_zero_comp;

    logic [63:0] r_hash;
    logic [IW-1:0] r_idx, r_next_tok, r_tok_start;
    t_ctx        r_ctx;
    logic [31:0] r_pend, r_zero_op;
    logic        r_zdef_hit, r_failed, r_end_seen;
    logic [1:0]  r_site_hits;
    logic [1:0]  r_byte;
    logic [31:0] r_word;
    logic        r_last;
    logic [31:0] r_patched;
    logic        r_extra;
    logic [1:0]  r_status;

    logic [63:0] hx;
    logic [63:0] hstep;
    assign hx = r_hash ^ {56'd0, r_word[8*r_byte +: 8]};
    assign hstep = (hx << 40) + (hx * 64'(FNV_PRIME[8:0]));

    logic [IW-1:0] s0, s1, zd;
    logic [31:0] d0, d1;
    logic        two;
    assign s0 = IW'(r_site0);
    assign s1 = IW'(r_site1);
    assign zd = IW'(r_zero_def);
    assign d0 = r_dests[31:0];
    assign d1 = r_dests[63:32];
    assign two = r_site_count[1];

    // token/operand evaluation
    t_ctx        e_ctx;
    logic [IW-1:0] e_next, e_tstart;
    logic [31:0] e_pend, e_zop, e_patched;
    logic        e_zseen, e_failed, e_end, e_extra;
    logic [1:0]  e_sseen;
    logic [IW:0] nxt_sum;
    logic [14:0] nops;
    logic        named;
    logic [IW-1:0] rel;

    always_comb begin
        e_ctx = r_ctx; e_next = r_next_tok; e_tstart = r_tok_start;
        e_pend = r_pend; e_zop = r_zero_op; e_zseen = r_zdef_hit;
        e_failed = r_failed; e_end = r_end_seen; e_sseen = r_site_hits;
        named = 1'b0;
        rel = r_idx - r_tok_start;
        nops = (r_word[15:0] == 16'hfffe) ? r_word[30:16] : {11'd0, r_word[27:24]};
        nxt_sum = {1'b0, r_idx} + (IW+1)'(nops) + 1'b1;
        if (r_idx == '0) begin
            if (r_word != PS_3_0) e_failed = 1'b1;
        end else if (r_end_seen) begin
            e_failed = 1'b1;
        end else if (r_idx == r_next_tok) begin
            e_ctx = CTX_PLAIN;
            e_tstart = r_idx;
            if (r_word[15:0] == 16'hffff) begin
                if (r_word != OP_END) e_failed = 1'b1;
                e_end = 1'b1;
            end else begin
                e_next = (nxt_sum > (IW+1)'(WORD_LIMIT + 1)) ? IW'(WORD_LIMIT + 1)
                                                             : nxt_sum[IW-1:0];
                if (r_idx == zd) begin
                    if (r_word != OP_DEF) e_failed = 1'b1;
                    else begin
                        e_zseen = 1'b1;
                        e_ctx = CTX_DEF;
                    end
                end
                if (r_site_count != 2'd0 && r_idx == s0) begin
                    if (r_word != OP_MOV || !e_zseen) e_failed = 1'b1;
                    e_pend = d0;
                    named = 1'b1;
                    if (e_sseen != 2'd3) e_sseen = e_sseen + 2'd1;
                end
                if (two && r_idx == s1) begin
                    if (r_word != OP_MOV || !e_zseen) e_failed = 1'b1;
                    if (!named) e_pend = d1;
                    named = 1'b1;
                    if (e_sseen != 2'd3) e_sseen = e_sseen + 2'd1;
                end
                if (named) e_ctx = CTX_SITE;
                else if (r_word == OP_MOV) e_ctx = CTX_MOV;
            end
        end else begin
            case (r_ctx)
                CTX_DEF: begin
                    if (rel == IW'(1)) begin
                        if ((r_word & ~32'h7ff) != DEF_DEST_BASE || r_word[10:0] >= 11'd224)
                            e_failed = 1'b1;
                        e_zop = 32'ha0000000 | {21'd0, r_word[10:0]}
                              | ({24'd0, 8'(r_zero_comp * 8'h55)} << 16);
                    end
                    if (rel == IW'(r_zero_comp) + IW'(2) && r_word != 32'd0) e_failed = 1'b1;
                end
                CTX_SITE: begin
                    if (rel == IW'(1) && r_word != r_pend) e_failed = 1'b1;
                    if (rel == IW'(2) && r_word != SRC_REQUIRED) e_failed = 1'b1;
                end
                CTX_MOV: begin
                    if (rel == IW'(1)) e_pend = r_word;
                    if (rel == IW'(2) && r_word == SRC_REQUIRED &&
                        (r_pend & ~DEST_FREE_MASK) == DEST_REQUIRED) e_failed = 1'b1;
                end
                default: ;
            endcase
        end
        e_patched = r_word;
        e_extra = 1'b0;
        if (r_site_count != 2'd0 && r_idx == s0) e_patched = OP_MAX;
        else if (r_site_count != 2'd0 && r_idx == s0 + IW'(1)) e_patched = d0 & ~SAT_BIT;
        else if (r_site_count != 2'd0 && r_idx == s0 + IW'(2)) begin
            e_patched = SRC_REQUIRED; e_extra = 1'b1;
        end else if (two && r_idx == s1) e_patched = OP_MAX;
        else if (two && r_idx == s1 + IW'(1)) e_patched = d1 & ~SAT_BIT;
        else if (two && r_idx == s1 + IW'(2)) begin
            e_patched = SRC_REQUIRED; e_extra = 1'b1;
        end
    end

    // final status from evaluated state
    logic [IW:0] n_cnt;
    logic        prof_ok;
    logic [1:0]  e_status;
    always_comb begin
        n_cnt = {1'b0, r_idx} + 1'b1;
        prof_ok = (r_site_count == 2'd1 || r_site_count == 2'd2)
               && s0 != '0 && (IW+1)'(s0) < n_cnt
               && (d0 & ~DEST_FREE_MASK) == DEST_REQUIRED
               && (!two || (s1 != '0 && (IW+1)'(s1) < n_cnt && s1 > s0
                            && (d1 & ~DEST_FREE_MASK) == DEST_REQUIRED))
               && !e_failed && e_end && e_zseen && e_sseen == r_site_count;
        if (n_cnt < (IW+1)'(2) || n_cnt > (IW+1)'(WORD_LIMIT)) e_status = ST_INVALID;
        else if (n_cnt != (IW+1)'(r_exp_count) || r_hash != r_exp_hash) e_status = ST_MISMATCH;
        else if (prof_ok) e_status = ST_APPLIED;
        else e_status = ST_BAD_PROF;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_valid;
    assign o_valid = (r_state == S_OUT1) || (r_state == S_OUT2) || (r_state == S_STAT);

    always_comb begin
        o_data = '0;
        case (r_state)
            S_OUT1: o_data.out_word = r_patched;
            S_OUT2: o_data.out_word = r_zero_op;
            S_STAT: begin
                o_data.kind = 1'b1;
                o_data.status = r_status;
                o_data.end_of_run = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_HASH;
            S_HASH: if (r_byte == 2'd3) n_state = S_EVAL;
            S_EVAL: n_state = S_OUT1;
            S_OUT1: if (!i_stall) n_state = r_last ? S_STAT : (r_extra ? S_OUT2 : S_IDLE);
            S_OUT2: if (!i_stall) n_state = S_IDLE;
            S_STAT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_exp_count <= '0; r_exp_hash <= '0; r_site_count <= '0;
            r_site0 <= '0; r_site1 <= '0; r_dests <= '0; r_zero_def <= '0;
            r_zero_comp <= '0;
            r_hash <= FNV_BASIS; r_idx <= '0; r_next_tok <= IW'(1); r_tok_start <= '0;
            r_ctx <= CTX_PLAIN; r_pend <= '0; r_zero_op <= '0; r_zdef_hit <= 1'b0;
            r_failed <= 1'b0; r_end_seen <= 1'b0; r_site_hits <= '0;
            r_byte <= '0; r_word <= '0; r_patched <= '0; r_status <= '0;
            r_extra <= 1'b0; r_last <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WORD_COUNT: r_exp_count <= i_cfg_data[20:0];
                    CFG_HASH:       r_exp_hash <= i_cfg_data;
                    CFG_SITE_COUNT: r_site_count <= i_cfg_data[1:0];
                    CFG_SITE0:      r_site0 <= i_cfg_data[19:0];
                    CFG_SITE1:      r_site1 <= i_cfg_data[19:0];
                    CFG_DESTS:      r_dests <= i_cfg_data;
                    CFG_ZERO_DEF:   r_zero_def <= i_cfg_data[19:0];
                    CFG_ZERO_COMP:  r_zero_comp <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_word <= i_data.word;
                    r_last <= i_data.last;
                    r_byte <= '0;
                end
                S_HASH: begin
                    r_hash <= hstep;
                    r_byte <= r_byte + 2'd1;
                end
                S_EVAL: begin
                    r_patched <= e_patched;
                    r_extra <= e_extra;
                    r_status <= e_status;
                    if (r_last) begin
                        r_hash <= FNV_BASIS; r_idx <= '0; r_next_tok <= IW'(1);
                        r_tok_start <= '0; r_ctx <= CTX_PLAIN; r_pend <= '0;
                        r_zero_op <= '0; r_zdef_hit <= 1'b0; r_failed <= 1'b0;
                        r_end_seen <= 1'b0; r_site_hits <= '0;
                    end else begin
                        r_ctx <= e_ctx; r_next_tok <= e_next; r_tok_start <= e_tstart;
                        r_pend <= e_pend; r_zero_op <= e_zop; r_zdef_hit <= e_zseen;
                        r_failed <= e_failed; r_end_seen <= e_end; r_site_hits <= e_sseen;
                        if (r_idx < IW'(WORD_LIMIT)) r_idx <= r_idx + IW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STAT) |-> r_last)
        else $error("status shown without a last word");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted while a result is pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT2) |-> (r_extra && !r_last))
        else $error("zero operand emitted outside a site");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx > IW'(WORD_LIMIT)) |-> 1'b0)
        else $error("word index beyond saturation");

endmodule
